FILE: src/cell_majority_color_label_assert.svh
// Assertion macros shared by the cell majority labeller RTL.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef CELL_MAJORITY_COLOR_LABEL_ASSERT_SVH
`define CELL_MAJORITY_COLOR_LABEL_ASSERT_SVH

// same-cycle implication
`define CMCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cmcl: same-cycle check failed");

// next-cycle implication
`define CMCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cmcl: next-cycle check failed");

`endif

FILE: src/cmcl_pkg.sv
// Shared types and constants for the cell majority labeller.
// No dependencies.
package cmcl_pkg;

	localparam int COLOR_W   = 24;
	localparam int SIZE_W    = 7;
	localparam int LCNT_W    = 3;
	localparam int LABEL_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_COLOR_REGS = 6;

	localparam int DEF_MAX_LABELS    = 6;
	localparam int DEF_MAX_CELL_SIZE = 64;
	localparam int RST_CELL_SIZE     = 8;

	typedef logic [COLOR_W-1:0] color_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SIZE   = 3'd0,
		REG_LABEL_COUNT = 3'd1,
		REG_COLOR_0     = 3'd2,
		REG_COLOR_1     = 3'd3,
		REG_COLOR_2     = 3'd4,
		REG_COLOR_3     = 3'd5,
		REG_COLOR_4     = 3'd6,
		REG_COLOR_5     = 3'd7
	} cfg_reg_t;

	// outcome of one pixel in the counting stage
	typedef struct packed {
		logic               done;
		logic               labeled;
		logic [LABEL_W-1:0] label;
	} cell_result_t;

endpackage

FILE: src/cell_majority_color_label.sv
// A cell's last pixel enters the input register; its result then loads out_valid_q.
// Throughput: one pixel per cycle while in_stall is low; counting is done in cmcl_count.
// A cell result waiting under out_stall holds back only the pixel that ends the next cell.
// Reset clears counters and both valid flags; config returns to cell_size 8, label_count 0,
// and all colors 0. Config is taken every cycle (cfg_ready is tied high).
// Depends on cmcl_pkg, cmcl_count and cell_majority_color_label_assert.svh.
`include "cell_majority_color_label_assert.svh"

module cell_majority_color_label #(
	parameter int MAX_LABELS    = cmcl_pkg::DEF_MAX_LABELS,
	parameter int MAX_CELL_SIZE = cmcl_pkg::DEF_MAX_CELL_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmcl_pkg::COLOR_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cmcl_pkg::COLOR_W-1:0]    pixel_rgb,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            cell_labeled,
	output logic [cmcl_pkg::LABEL_W-1:0]    cell_label
);
	import cmcl_pkg::*;

	localparam int MAX_AREA  = MAX_CELL_SIZE * MAX_CELL_SIZE;
	localparam int CNT_W     = $clog2(MAX_AREA + 1);
	localparam int RST_SIZE  = (RST_CELL_SIZE > MAX_CELL_SIZE) ? MAX_CELL_SIZE : RST_CELL_SIZE;
	localparam int RST_AREA  = RST_SIZE * RST_SIZE;

	logic [CNT_W-1:0]  area_q;
	logic [LCNT_W-1:0] n_used_q;
	color_t            color_q [MAX_LABELS];

	logic [SIZE_W-1:0]   size_eff;
	logic [2*SIZE_W-1:0] size_sq;
	logic [LCNT_W-1:0]   n_eff;
	logic [CFG_IDX_W-1:0] color_idx;
	logic                cfg_we;

	logic   s1_valid_q;
	color_t pixel_s1;
	logic   s1_go;
	logic   accept;
	cell_result_t res;

	logic               out_valid_q;
	logic               labeled_q;
	logic [LABEL_W-1:0] label_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign color_idx = cfg_index - CFG_IDX_W'(REG_COLOR_0);

	always_comb begin
		size_eff = cfg_data[SIZE_W-1:0];
		if (size_eff == '0)
			size_eff = SIZE_W'(1);
		else if (size_eff > SIZE_W'(MAX_CELL_SIZE))
			size_eff = SIZE_W'(MAX_CELL_SIZE);
		size_sq = (2*SIZE_W)'(size_eff) * (2*SIZE_W)'(size_eff);
		n_eff = cfg_data[LCNT_W-1:0];
		if (n_eff > LCNT_W'(MAX_LABELS))
			n_eff = LCNT_W'(MAX_LABELS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q   <= CNT_W'(RST_AREA);
			n_used_q <= '0;
			for (int i = 0; i < MAX_LABELS; i++)
				color_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_SIZE:   area_q   <= size_sq[CNT_W-1:0];
				REG_LABEL_COUNT: n_used_q <= n_eff;
				default: begin
					// colors beyond MAX_LABELS are never compared, so not stored
					for (int i = 0; i < MAX_LABELS; i++)
						if (color_idx == CFG_IDX_W'(i))
							color_q[i] <= cfg_data;
				end
			endcase
		end
	end

	// ---------------- input register ----------------
	// a pixel that ends a cell waits while the result register is full and stalled
	assign s1_go    = s1_valid_q && (!res.done || !out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (s1_go)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			pixel_s1 <= pixel_rgb;
	end

	cmcl_count #(
		.MAX_LABELS (MAX_LABELS),
		.CNT_W      (CNT_W)
	) u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_go),
		.pixel  (pixel_s1),
		.colors (color_q),
		.n_used (n_used_q),
		.area   (area_q),
		.res    (res)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go && res.done)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && res.done) begin
			labeled_q <= res.labeled;
			label_q   <= res.label;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_labeled = labeled_q;
	assign cell_label   = label_q;

	// ---------------- checks ----------------
	`CMCL_ASSERT_NOW(a_unlabeled_zero, clk, arst_n, out_valid_q && !labeled_q, label_q == '0)
	`CMCL_ASSERT_NOW(a_label_range, clk, arst_n, out_valid_q, label_q < LABEL_W'(MAX_LABELS))
	`CMCL_ASSERT_NOW(a_free_out_no_stall, clk, arst_n, !out_valid_q, !in_stall)
	`CMCL_ASSERT_NEXT(a_done_loads_out, clk, arst_n, s1_go && res.done, out_valid_q)

endmodule

FILE: src/cmcl_count.sv
// Color match, per-label counters and majority decision for one pixel.
// Depends on cmcl_pkg.
module cmcl_count #(
	parameter int MAX_LABELS = cmcl_pkg::DEF_MAX_LABELS,
	parameter int CNT_W      = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  cmcl_pkg::color_t           pixel,
	input  cmcl_pkg::color_t           colors [MAX_LABELS],
	input  logic [cmcl_pkg::LCNT_W-1:0] n_used,
	input  logic [CNT_W-1:0]           area,
	output cmcl_pkg::cell_result_t     res
);
	import cmcl_pkg::*;

	logic [CNT_W-1:0] cnt_q  [MAX_LABELS];
	logic [CNT_W-1:0] cnt_nx [MAX_LABELS];
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_nx;
	logic [MAX_LABELS-1:0] first;

	// lowest matching entry wins
	always_comb begin
		logic taken;
		taken = 1'b0;
		for (int i = 0; i < MAX_LABELS; i++) begin
			first[i] = 1'b0;
			if (!taken && (LCNT_W'(i) < n_used) && (pixel == colors[i])) begin
				first[i] = 1'b1;
				taken = 1'b1;
			end
		end
	end

	assign seen_nx = seen_q + CNT_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_LABELS; i++)
			cnt_nx[i] = cnt_q[i] + CNT_W'(first[i]);
	end

	// highest index over half the area wins, as the counts may exceed it after a resize
	always_comb begin
		res.done    = (seen_nx >= area);
		res.labeled = 1'b0;
		res.label   = '0;
		for (int i = 0; i < MAX_LABELS; i++) begin
			if ((LCNT_W'(i) < n_used) && ({cnt_nx[i], 1'b0} > {1'b0, area})) begin
				res.labeled = 1'b1;
				res.label   = LABEL_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < MAX_LABELS; i++)
				cnt_q[i] <= '0;
		end else if (fire) begin
			if (res.done) begin
				seen_q <= '0;
				for (int i = 0; i < MAX_LABELS; i++)
					cnt_q[i] <= '0;
			end else begin
				seen_q <= seen_nx;
				for (int i = 0; i < MAX_LABELS; i++)
					cnt_q[i] <= cnt_nx[i];
			end
		end
	end

endmodule
